// ----- hw/rtl/rrl_pkg.sv -----
`timescale 1ns / 1ps

package rrl_pkg;

	// Token text kept per token is at most TEXT_LIMIT-1 characters
	localparam int TEXT_LIMIT  = 128;
	localparam int CNT_W       = $clog2(TEXT_LIMIT);
	localparam int LEN_W       = 7;
	localparam int VAL_W       = 31;
	localparam int KIND_W      = 5;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [VAL_W-1:0] NUM_MAX = '1;

	// Characters of interest
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_W      = 8'h57;

	// Character classes
	localparam logic [3:0] CLS_OTHER  = 4'd0;
	localparam logic [3:0] CLS_SPACE  = 4'd1;
	localparam logic [3:0] CLS_DIGIT  = 4'd2;
	localparam logic [3:0] CLS_ALPHA  = 4'd3;
	localparam logic [3:0] CLS_PLUS   = 4'd4;
	localparam logic [3:0] CLS_MINUS  = 4'd5;
	localparam logic [3:0] CLS_DOLLAR = 4'd6;
	localparam logic [3:0] CLS_HASH   = 4'd7;
	localparam logic [3:0] CLS_NUL    = 4'd8;

	// Lexer states
	localparam logic [2:0] LX_START  = 3'd0;
	localparam logic [2:0] LX_NUMBER = 3'd1;
	localparam logic [2:0] LX_PAIR   = 3'd2;
	localparam logic [2:0] LX_WEEK   = 3'd3;
	localparam logic [2:0] LX_LETTER = 3'd4;
	localparam logic [2:0] LX_DATE   = 3'd5;

	// Token kinds
	localparam logic [KIND_W-1:0] TK_EOL      = 5'd0;
	localparam logic [KIND_W-1:0] TK_ERROR    = 5'd1;
	localparam logic [KIND_W-1:0] TK_NUMBER   = 5'd2;
	localparam logic [KIND_W-1:0] TK_DATE     = 5'd3;
	localparam logic [KIND_W-1:0] TK_END      = 5'd4;
	localparam logic [KIND_W-1:0] TK_DURATION = 5'd5;
	localparam logic [KIND_W-1:0] TK_M        = 5'd6;
	localparam logic [KIND_W-1:0] TK_D        = 5'd7;
	localparam logic [KIND_W-1:0] TK_W        = 5'd8;
	localparam logic [KIND_W-1:0] TK_MP       = 5'd9;
	localparam logic [KIND_W-1:0] TK_MD       = 5'd10;
	localparam logic [KIND_W-1:0] TK_YD       = 5'd11;
	localparam logic [KIND_W-1:0] TK_YM       = 5'd12;
	localparam logic [KIND_W-1:0] TK_LD       = 5'd13;
	localparam logic [KIND_W-1:0] TK_SU       = 5'd14;
	localparam logic [KIND_W-1:0] TK_MO       = 5'd15;
	localparam logic [KIND_W-1:0] TK_TU       = 5'd16;
	localparam logic [KIND_W-1:0] TK_WE       = 5'd17;
	localparam logic [KIND_W-1:0] TK_TH       = 5'd18;
	localparam logic [KIND_W-1:0] TK_FR       = 5'd19;
	localparam logic [KIND_W-1:0] TK_SA       = 5'd20;
	localparam logic [KIND_W-1:0] TK_W1P      = 5'd21;
	localparam logic [KIND_W-1:0] TK_W1M      = 5'd26;

	// Two-letter words
	localparam logic [15:0] PAIR_MP = "MP";
	localparam logic [15:0] PAIR_MD = "MD";
	localparam logic [15:0] PAIR_YD = "YD";
	localparam logic [15:0] PAIR_YM = "YM";
	localparam logic [15:0] PAIR_LD = "LD";
	localparam logic [15:0] PAIR_SU = "SU";
	localparam logic [15:0] PAIR_MO = "MO";
	localparam logic [15:0] PAIR_TU = "TU";
	localparam logic [15:0] PAIR_WE = "WE";
	localparam logic [15:0] PAIR_TH = "TH";
	localparam logic [15:0] PAIR_FR = "FR";
	localparam logic [15:0] PAIR_SA = "SA";

	// One step of work for the back: scan the held character, then maybe NUL
	typedef struct packed {
		logic       scan_pend;
		logic [7:0] pend_char;
		logic [3:0] pend_cls;
		logic [3:0] la_cls;
		logic       nul;
	} entry_t;

	typedef struct packed {
		logic [2:0]       st;
		logic [7:0]       prev;
		logic [7:0]       first;
		logic [VAL_W-1:0] acc;
		logic [CNT_W-1:0] cnt;
	} lex_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [VAL_W-1:0]  value;
		logic [LEN_W-1:0]  len;
		logic              last;
	} tok_t;

	function automatic logic [3:0] classify(input logic [7:0] c);
		logic [3:0] k;
		if (c == CH_NUL)
			k = CLS_NUL;
		else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
			k = CLS_SPACE;
		else if (c >= CH_ZERO && c <= CH_NINE)
			k = CLS_DIGIT;
		else if ((c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z))
			k = CLS_ALPHA;
		else if (c == CH_PLUS)
			k = CLS_PLUS;
		else if (c == CH_MINUS)
			k = CLS_MINUS;
		else if (c == CH_DOLLAR)
			k = CLS_DOLLAR;
		else if (c == CH_HASH)
			k = CLS_HASH;
		else
			k = CLS_OTHER;
		return k;
	endfunction

	// Case-sensitive match of a two-letter word
	function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
		logic [KIND_W-1:0] k;
		unique case ({a, b})
			PAIR_MP: k = TK_MP;
			PAIR_MD: k = TK_MD;
			PAIR_YD: k = TK_YD;
			PAIR_YM: k = TK_YM;
			PAIR_LD: k = TK_LD;
			PAIR_SU: k = TK_SU;
			PAIR_MO: k = TK_MO;
			PAIR_TU: k = TK_TU;
			PAIR_WE: k = TK_WE;
			PAIR_TH: k = TK_TH;
			PAIR_FR: k = TK_FR;
			PAIR_SA: k = TK_SA;
			default: k = TK_ERROR;
		endcase
		return k;
	endfunction

	// Token length saturates at 127
	function automatic logic [LEN_W-1:0] len_sat(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+7:0] w;
		w = {8'b0, cnt};
		return (w > (CNT_W+8)'(127)) ? 7'd127 : w[LEN_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/rrl_fifo.sv -----
`timescale 1ns / 1ps

module rrl_fifo
	import rrl_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_data,
	output logic   full,
	input  logic   pop,
	output entry_t rd_data,
	output logic   empty
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop && !empty)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// The front never offers a step while the queue is full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("step pushed into full queue");

endmodule

// ----- hw/rtl/rrl_front.sv -----
`timescale 1ns / 1ps

module rrl_front
	import rrl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] character,
	output logic       push,
	output entry_t     entry,
	input  logic       full
);

	logic       accept;
	logic [3:0] cls_in;
	logic       pend_valid_q;
	logic [7:0] pend_char_q;
	logic [3:0] pend_cls_q;

	assign char_stall = full;
	assign accept     = char_valid && !full;
	assign cls_in     = classify(character);

	// New character is lookahead for the held one; NUL also asks for its own scan
	assign entry.scan_pend = pend_valid_q;
	assign entry.pend_char = pend_char_q;
	assign entry.pend_cls  = pend_cls_q;
	assign entry.la_cls    = cls_in;
	assign entry.nul       = (cls_in == CLS_NUL);
	assign push            = accept && (pend_valid_q || cls_in == CLS_NUL);

	// Held character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_char_q  <= CH_NUL;
			pend_cls_q   <= CLS_NUL;
		end else if (accept) begin
			if (cls_in == CLS_NUL) begin
				pend_valid_q <= 1'b0;
				pend_char_q  <= CH_NUL;
				pend_cls_q   <= CLS_NUL;
			end else begin
				pend_valid_q <= 1'b1;
				pend_char_q  <= character;
				pend_cls_q   <= cls_in;
			end
		end
	end

endmodule

// ----- hw/rtl/rrl_back.sv -----
`timescale 1ns / 1ps

module rrl_back
	import rrl_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t head,
	input  logic   head_valid,
	output logic   pop,
	output logic   tok_valid,
	input  logic   tok_stall,
	output tok_t   tok
);

	typedef struct packed {
		lex_t s;
		logic emit;
		tok_t tok;
		logic again;
	} pass_t;

	typedef struct packed {
		lex_t s;
		logic v0;
		tok_t t0;
		logic v1;
		tok_t t1;
	} scan_t;

	// One pass of the lexer over character c
	function automatic pass_t lex_pass(input lex_t s, input logic [7:0] c,
			input logic [3:0] cc, input logic [3:0] la);
		pass_t            r;
		logic             kept;
		logic [CNT_W-1:0] cnt_k;
		logic [34:0]      prod;
		logic [7:0]       dp;
		r     = '0;
		r.s   = s;
		kept  = (s.cnt < CNT_W'(TEXT_LIMIT - 1));
		cnt_k = kept ? s.cnt + CNT_W'(1) : s.cnt;
		prod  = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + {31'b0, c[3:0]};
		dp    = s.prev - CH_ZERO;
		unique case (s.st)
			LX_START: begin
				unique case (cc)
					CLS_SPACE: begin
					end
					CLS_NUL: begin
						r.emit     = 1'b1;
						r.tok.kind = TK_EOL;
					end
					CLS_DIGIT: begin
						r.s.cnt   = CNT_W'(1);
						r.s.acc   = VAL_W'(c[3:0]);
						r.s.first = c;
						r.s.st    = (la == CLS_PLUS || la == CLS_MINUS) ? LX_WEEK : LX_NUMBER;
					end
					CLS_ALPHA: begin
						r.s.cnt   = CNT_W'(1);
						r.s.acc   = '0;
						r.s.first = c;
						r.s.st    = (la == CLS_ALPHA) ? LX_PAIR : LX_LETTER;
					end
					CLS_DOLLAR: begin
						r.emit     = 1'b1;
						r.tok.kind = TK_END;
						r.tok.len  = LEN_W'(1);
					end
					CLS_HASH: begin
						r.emit     = 1'b1;
						r.tok.kind = TK_DURATION;
						r.tok.len  = LEN_W'(1);
					end
					default: begin
						r.emit     = 1'b1;
						r.tok.kind = TK_ERROR;
						r.tok.len  = LEN_W'(1);
					end
				endcase
			end
			LX_NUMBER: begin
				if (cc == CLS_DIGIT) begin
					if (kept) begin
						r.s.cnt = cnt_k;
						r.s.acc = (prod > 35'(NUM_MAX)) ? NUM_MAX : prod[VAL_W-1:0];
					end
				end else if (cc == CLS_SPACE || cc == CLS_NUL) begin
					r.emit      = 1'b1;
					r.tok.kind  = TK_NUMBER;
					r.tok.value = s.acc;
					r.tok.len   = len_sat(s.cnt);
					r.again     = 1'b1;
				end else begin
					r.s.cnt = cnt_k;
					r.s.acc = '0;
					r.s.st  = LX_DATE;
				end
			end
			LX_PAIR: begin
				r.emit     = 1'b1;
				r.tok.kind = pair_kind(s.first, c);
				r.tok.len  = len_sat(cnt_k);
			end
			LX_WEEK, LX_LETTER: begin
				if (s.st == LX_WEEK && (cc == CLS_PLUS || cc == CLS_MINUS)) begin
					// week position: digit 1..5 then sign
					r.emit    = 1'b1;
					r.tok.len = len_sat(cnt_k);
					if (dp >= 8'd1 && dp <= 8'd5)
						r.tok.kind = ((cc == CLS_PLUS) ? TK_W1P : TK_W1M) + KIND_W'(dp - 8'd1);
					else
						r.tok.kind = TK_ERROR;
				end else if (cc != CLS_DIGIT) begin
					// letter (or week digit) not followed by a digit eats the next character
					r.emit     = 1'b1;
					r.tok.kind = TK_ERROR;
					r.tok.len  = len_sat((cc != CLS_NUL) ? cnt_k : s.cnt);
				end else begin
					// interval command; the digit is scanned again
					r.emit    = 1'b1;
					r.tok.len = len_sat(s.cnt);
					r.again   = 1'b1;
					case (s.prev)
						CH_D:    r.tok.kind = TK_D;
						CH_M:    r.tok.kind = TK_M;
						CH_W:    r.tok.kind = TK_W;
						default: r.tok.kind = TK_ERROR;
					endcase
				end
			end
			LX_DATE: begin
				if (cc == CLS_SPACE || cc == CLS_NUL) begin
					r.emit     = 1'b1;
					r.tok.kind = TK_DATE;
					r.tok.len  = len_sat(s.cnt);
					r.again    = 1'b1;
				end else begin
					r.s.cnt = cnt_k;
				end
			end
			default: begin
				r.emit     = 1'b1;
				r.tok.kind = TK_ERROR;
				r.tok.len  = len_sat(s.cnt);
			end
		endcase
		// Every token leaves the lexer in its start state
		if (r.emit) begin
			r.s.st  = LX_START;
			r.s.cnt = '0;
			r.s.acc = '0;
		end
		return r;
	endfunction

	// Full scan of one character: a pass and at most one rescan
	function automatic scan_t lex_scan(input lex_t s, input logic [7:0] c,
			input logic [3:0] cc, input logic [3:0] la);
		scan_t r;
		pass_t p1;
		pass_t p2;
		r  = '0;
		p1 = lex_pass(s, c, cc, la);
		p2 = lex_pass(p1.s, c, cc, la);
		r.v0 = p1.emit;
		r.t0 = p1.tok;
		if (p1.again) begin
			r.s  = p2.s;
			r.v1 = p2.emit;
			r.t1 = p2.tok;
		end else begin
			r.s = p1.s;
		end
		r.s.prev = c;
		return r;
	endfunction

	lex_t       lex_q;
	tok_t       buf_q [3];
	logic [1:0] cnt_q;

	scan_t      sc1;
	scan_t      sc2;
	lex_t       s_mid;
	lex_t       s_new;
	tok_t       cand   [4];
	logic [3:0] cand_v;
	tok_t       new_tok [3];
	logic [1:0] n_new;
	logic       take;

	// Whole step: held character first, then the NUL if there is one
	always_comb begin
		sc1   = lex_scan(lex_q, head.pend_char, head.pend_cls, head.la_cls);
		s_mid = head.scan_pend ? sc1.s : lex_q;
		sc2   = lex_scan(s_mid, CH_NUL, CLS_NUL, CLS_NUL);
		s_new = head.nul ? sc2.s : s_mid;
		cand[0]   = sc1.t0;
		cand[1]   = sc1.t1;
		cand[2]   = sc2.t0;
		cand[3]   = sc2.t1;
		cand_v[0] = head.scan_pend && sc1.v0;
		cand_v[1] = head.scan_pend && sc1.v1;
		cand_v[2] = head.nul && sc2.v0;
		cand_v[3] = head.nul && sc2.v1;
	end

	// Pack the step's tokens in order and flag the final one
	always_comb begin
		new_tok = '{default: '0};
		n_new   = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i] && n_new != 2'd3) begin
				new_tok[n_new] = cand[i];
				n_new          = n_new + 2'd1;
			end
		end
		if (n_new != 2'd0)
			new_tok[n_new - 2'd1].last = 1'b1;
	end

	// Output buffer handshake
	assign tok_valid = (cnt_q != 2'd0);
	assign tok       = buf_q[0];
	assign take      = tok_valid && !tok_stall;
	assign pop       = head_valid && (cnt_q == 2'd0 || (cnt_q == 2'd1 && take));

	// Token buffer contents
	always_ff @(posedge clk) begin
		if (pop) begin
			buf_q <= new_tok;
		end else if (take) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	// Lexer state and buffer fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q <= '0;
			cnt_q <= 2'd0;
		end else begin
			if (pop) begin
				lex_q <= s_new;
				cnt_q <= n_new;
			end else if (take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && cnt_q == 2'd1) |-> buf_q[0].last)
		else $error("final buffered token lacks last flag");

	a_nul_start: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.nul) |=> (lex_q.st == LX_START))
		else $error("lexer not in start state after end of text");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		lex_q.cnt <= CNT_W'(TEXT_LIMIT - 1))
		else $error("text count beyond limit");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && buf_q[0].kind != TK_NUMBER) |-> (buf_q[0].value == '0))
		else $error("non-number token carries a value");

endmodule

// ----- hw/rtl/recurrence_rule_lexer.sv -----
`timescale 1ns / 1ps

// Repeat-rule lexer. Takes one text character per transaction and gives tokens,
// each with a kind, a value (numbers only), a length and a flag on the last token
// caused by that character. A character is held back until the next one arrives,
// as its lookahead; NUL ends the text and flushes. Characters are accepted one per
// cycle while the step queue is not full: the front classifies them into a
// four-entry step queue, and the back lexes one step per cycle into a three-token
// output buffer that delivers one token per cycle while tok_stall is low. The back
// takes a new step only when the buffer is empty or its last token is being taken,
// so a step that yields two or three tokens holds the back until they drain.

module recurrence_rule_lexer
	import rrl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  logic [7:0]        character,
	output logic              tok_valid,
	input  logic              tok_stall,
	output logic [KIND_W-1:0] token_kind,
	output logic [VAL_W-1:0]  number_value,
	output logic [LEN_W-1:0]  token_length,
	output logic              last_of_run
);

	logic   push;
	logic   full;
	logic   empty;
	logic   pop;
	entry_t wr_entry;
	entry_t head;
	tok_t   tok;

	rrl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.character  (character),
		.push       (push),
		.entry      (wr_entry),
		.full       (full)
	);

	rrl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_entry),
		.full    (full),
		.pop     (pop),
		.rd_data (head),
		.empty   (empty)
	);

	rrl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!empty),
		.pop        (pop),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok        (tok)
	);

	assign token_kind   = tok.kind;
	assign number_value = tok.value;
	assign token_length = tok.len;
	assign last_of_run  = tok.last;

endmodule

// ----- test/token_checker.sv -----
`timescale 1ns / 1ps

// Watches the character and token channels, predicts the tokens for every
// accepted character and compares them in order with those the lexer delivers.
module token_checker
	import rrl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	input  logic              char_stall,
	input  logic [7:0]        character,
	input  logic              tok_valid,
	input  logic              tok_stall,
	input  logic [KIND_W-1:0] token_kind,
	input  logic [VAL_W-1:0]  number_value,
	input  logic [LEN_W-1:0]  token_length,
	input  logic              last_of_run,
	output int                fail_count = 0,
	output int                pending = 0
);

	// Tokens predicted but not yet delivered, oldest first
	tok_t token_q[$];
	tok_t want;

	// Predicted lexer state
	logic [7:0]       held_char = '0;
	logic             held = 1'b0;
	logic [2:0]       lex_st = LX_START;
	logic [7:0]       prev_c = '0;
	logic [7:0]       first_c = '0;
	logic [VAL_W-1:0] acc = '0;
	int               kept = 0;

	// Tokens caused by the current character
	tok_t step_tok [3];
	int   step_n = 0;

	task automatic report(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
	endfunction

	function automatic logic [15:0] word_at(input int i);
		logic [15:0] w;
		case (i)
			0: w = PAIR_MP;
			1: w = PAIR_MD;
			2: w = PAIR_YD;
			3: w = PAIR_YM;
			4: w = PAIR_LD;
			5: w = PAIR_SU;
			6: w = PAIR_MO;
			7: w = PAIR_TU;
			8: w = PAIR_WE;
			9: w = PAIR_TH;
			10: w = PAIR_FR;
			default: w = PAIR_SA;
		endcase
		return w;
	endfunction

	// Word kinds run in the same order as the word list
	function automatic logic [KIND_W-1:0] word_kind(input logic [7:0] a, input logic [7:0] b);
		logic [KIND_W-1:0] k;
		k = TK_ERROR;
		for (int i = 0; i < 12; i++)
			if (word_at(i) == {a, b})
				k = KIND_W'(TK_MP + i);
		return k;
	endfunction

	// Count one more character of token text, up to the text limit
	function automatic bit keep_char();
		if (kept < TEXT_LIMIT - 1) begin
			kept++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Every token sends the lexer back to its start state
	task automatic push_token(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value,
			input int len);
		tok_t t;
		if (step_n < 3) begin
			t.kind = kind;
			t.value = value;
			t.len = (len > 127) ? 7'd127 : LEN_W'(len);
			t.last = 1'b0;
			step_tok[step_n] = t;
			step_n++;
		end
		lex_st = LX_START;
		kept = 0;
		acc = '0;
	endtask

	// Scan one character with its lookahead; a delimiter ending a token is rescanned
	task automatic lex_char(input logic [7:0] c, input logic [7:0] la);
		bit again;
		int d;
		longint v;
		logic [KIND_W-1:0] k;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			if (lex_st == LX_START) begin
				if (is_blank(c)) begin
				end else if (c == CH_NUL) begin
					push_token(TK_EOL, '0, 0);
				end else if (is_num(c)) begin
					kept = 0;
					void'(keep_char());
					acc = VAL_W'(c - CH_ZERO);
					first_c = c;
					lex_st = (la == CH_PLUS || la == CH_MINUS) ? LX_WEEK : LX_NUMBER;
				end else if (is_letter(c)) begin
					kept = 0;
					void'(keep_char());
					acc = '0;
					first_c = c;
					lex_st = is_letter(la) ? LX_PAIR : LX_LETTER;
				end else if (c == CH_DOLLAR) begin
					push_token(TK_END, '0, 1);
				end else if (c == CH_HASH) begin
					push_token(TK_DURATION, '0, 1);
				end else begin
					push_token(TK_ERROR, '0, 1);
				end
			end else if (lex_st == LX_NUMBER) begin
				if (is_num(c)) begin
					if (keep_char()) begin
						v = longint'(acc) * 10 + longint'(c) - longint'(CH_ZERO);
						acc = (v > longint'(NUM_MAX)) ? NUM_MAX : v[VAL_W-1:0];
					end
				end else if (is_blank(c) || c == CH_NUL) begin
					push_token(TK_NUMBER, acc, kept);
					again = 1'b1;
				end else begin
					// anything else turns the number into a date
					void'(keep_char());
					acc = '0;
					lex_st = LX_DATE;
				end
			end else if (lex_st == LX_PAIR) begin
				void'(keep_char());
				push_token(word_kind(first_c, c), '0, kept);
			end else if (lex_st == LX_WEEK && (c == CH_PLUS || c == CH_MINUS)) begin
				d = int'(prev_c) - int'(CH_ZERO);
				k = TK_ERROR;
				void'(keep_char());
				if (d >= 1 && d <= 5)
					k = (c == CH_PLUS) ? KIND_W'(TK_W1P + d - 1) : KIND_W'(TK_W1M + d - 1);
				push_token(k, '0, kept);
			end else if (lex_st == LX_DATE) begin
				if (is_blank(c) || c == CH_NUL) begin
					push_token(TK_DATE, '0, kept);
					again = 1'b1;
				end else begin
					void'(keep_char());
				end
			end else begin
				// single letter: needs a digit, which is then rescanned
				if (!is_num(c)) begin
					if (c != CH_NUL)
						void'(keep_char());
					push_token(TK_ERROR, '0, kept);
				end else begin
					k = TK_ERROR;
					if (prev_c == CH_D)
						k = TK_D;
					else if (prev_c == CH_M)
						k = TK_M;
					else if (prev_c == CH_W)
						k = TK_W;
					push_token(k, '0, kept);
					again = 1'b1;
				end
			end
		end
		prev_c = c;
	endtask

	// One character transaction: scan the held one, flush on NUL
	task automatic take_char(input logic [7:0] c);
		step_n = 0;
		if (held)
			lex_char(held_char, c);
		if (c == CH_NUL) begin
			lex_char(CH_NUL, CH_NUL);
			held = 1'b0;
			held_char = '0;
		end else begin
			held_char = c;
			held = 1'b1;
		end
		if (step_n > 0)
			step_tok[step_n-1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			token_q.push_back(step_tok[i]);
	endtask

	// Predict on accepted characters, compare accepted tokens
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall)
				take_char(character);
			if (tok_valid && !tok_stall) begin
				if (token_q.size() == 0) begin
					report($sformatf("unexpected token kind %0d length %0d",
						token_kind, token_length));
				end else begin
					want = token_q.pop_front();
					if (token_kind !== want.kind)
						report($sformatf("token_kind %0d, expected %0d", token_kind, want.kind));
					if (number_value !== want.value)
						report($sformatf("number_value %0d, expected %0d",
							number_value, want.value));
					if (token_length !== want.len)
						report($sformatf("token_length %0d, expected %0d",
							token_length, want.len));
					if (last_of_run !== want.last)
						report($sformatf("last_of_run %0d, expected %0d",
							last_of_run, want.last));
				end
			end
			pending <= token_q.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

// Feeds rule text to the lexer: a directed opening, then random token
// sequences with separators, noise and end-of-line, under random gaps and stalls.
module testbench;
	import rrl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 380;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              char_valid = 1'b0;
	logic              char_stall;
	logic [7:0]        character = '0;
	logic              tok_valid;
	logic              tok_stall = 1'b0;
	logic [KIND_W-1:0] token_kind;
	logic [VAL_W-1:0]  number_value;
	logic [LEN_W-1:0]  token_length;
	logic              last_of_run;

	int fail_count;
	int pending;
	int cycles = 0;
	int burst_left = 0;
	int sent_items = 0;
	bit hold_req = 1'b0;
	bit second_hold = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	recurrence_rule_lexer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.character    (character),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.number_value (number_value),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	token_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.character    (character),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.number_value (number_value),
		.token_length (token_length),
		.last_of_run  (last_of_run),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Token side: stall patterns in segments, plus long hold-offs on request
	initial begin
		int seg;
		int mode;
		seg = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				tok_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (seg == 0) begin
					mode = $urandom_range(0, 3);
					seg = $urandom_range(10, 80);
				end
				seg--;
				case (mode)
					0: tok_stall <= 1'b0;
					1: tok_stall <= ($urandom_range(0, 3) == 0);
					2: tok_stall <= ($urandom_range(0, 3) != 0);
					default: tok_stall <= (seg % 5 < 2);
				endcase
			end
		end
	end

	function automatic logic [7:0] digit_char();
		return 8'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	// One character transaction; bursts of random length with gaps between
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				char_valid <= 1'b0;
				gap = $urandom_range(1, 6);
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		char_valid <= 1'b1;
		character <= c;
		do @(posedge clk); while (char_stall);
		burst_left--;
		sent_items++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// One random token, mostly well formed, then usually a separator
	task automatic send_token();
		int pick;
		int n;
		int i;
		logic [7:0] c;
		string words;
		string letters;
		words = "MPMDYDYMLDSUMOTUWETHFRSA";
		letters = "MDW";
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			// number, now and then past the text limit
			n = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 150) : $urandom_range(1, 12);
			repeat (n) send_char(digit_char());
		end else if (pick < 30) begin
			// date-like: digits, then any printable run
			n = ($urandom_range(0, 29) == 0) ? $urandom_range(128, 150) : $urandom_range(1, 10);
			repeat ($urandom_range(1, 8)) send_char(digit_char());
			repeat (n) send_char(8'($urandom_range(33, 126)));
		end else if (pick < 50) begin
			// two-letter word, sometimes with a lower-case first letter or random
			i = $urandom_range(0, 11);
			case ($urandom_range(0, 9))
				0: begin
					send_char(words[2*i] | 8'h20);
					send_char(words[2*i+1]);
				end
				1: begin
					send_char(8'($urandom_range(CH_UC_A, CH_UC_Z)));
					send_char(8'($urandom_range(CH_LC_A, CH_LC_Z)));
				end
				default: begin
					send_char(words[2*i]);
					send_char(words[2*i+1]);
				end
			endcase
		end else if (pick < 65) begin
			// interval letter and its digits, or a letter left without one
			if ($urandom_range(0, 9) < 8)
				c = letters[$urandom_range(0, 2)];
			else
				c = 8'($urandom_range(CH_UC_A, CH_UC_Z));
			send_char(c);
			case ($urandom_range(0, 9))
				0: send_char(8'($urandom_range(33, 47)));
				1: send_char(CH_NUL);
				default: repeat ($urandom_range(1, 3)) send_char(digit_char());
			endcase
		end else if (pick < 75) begin
			// week position, mostly 1..5
			if ($urandom_range(0, 4) == 0)
				send_char(digit_char());
			else
				send_char(8'(CH_ZERO + $urandom_range(1, 5)));
			send_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
		end else if (pick < 81) begin
			send_char($urandom_range(0, 1) ? CH_DOLLAR : CH_HASH);
		end else if (pick < 90) begin
			send_char(8'($urandom_range(1, 255)));
		end else begin
			send_char(CH_NUL);
		end
		if ($urandom_range(0, 9) != 0)
			send_char(($urandom_range(0, 3) == 0) ? 8'($urandom_range(CH_TAB, CH_CR)) : CH_SPACE);
	endtask

	// Stimulus and verdict
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturating number, command with digit, wrong letter, bad week, bad pair,
		// lone letter before NUL, high byte, markers, minus week and end-of-line
		send_str("9999999999\tM1 Q5 7+Xy W");
		send_char(CH_NUL);
		send_char(8'h80);
		send_char(CH_DOLLAR);
		send_char(CH_HASH);
		send_str("1-");
		send_char(CH_NUL);

		hold_req = 1'b1;
		while (sent_items < ITEM_TARGET) begin
			send_token();
			if (sent_items >= ITEM_TARGET / 2 && !second_hold) begin
				hold_req = 1'b1;
				second_hold = 1'b1;
			end
		end
		send_char(CH_NUL);
		char_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
